FILE: src/personalized_pagerank_engine_top_macros.svh
// assertion macros for the pagerank engine top level
`ifndef PERSONALIZED_PAGERANK_ENGINE_TOP_MACROS_SVH
`define PERSONALIZED_PAGERANK_ENGINE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ppr_pkg.sv
// shared constants, codes and controller/datapath types
`default_nettype none
package ppr_pkg;
    localparam int NODE_AW   = 10;
    localparam int MAX_NODES = 1 << NODE_AW;
    localparam int EDGE_AW   = 12;
    localparam int MAX_EDGES = 1 << EDGE_AW;
    localparam int VAL_W     = 32;
    localparam int SCORE_W   = 48;
    localparam int OWS_W     = VAL_W + EDGE_AW;
    localparam int NORM_W    = 33;
    localparam int DIFF_W    = SCORE_W + NODE_AW;
    localparam int EDGE_W    = 2 * NODE_AW + VAL_W;
    localparam int CNT_W     = 16;
    localparam int LO_W      = 17;
    localparam int DAMP_W    = 16;
    localparam int DIV_CW    = 6;

    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    typedef enum logic [1:0] {
        CMD_LOAD_EDGE = 2'd0,
        CMD_LOAD_PREF = 2'd1,
        CMD_RUN       = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd_code;

    typedef enum logic [2:0] {
        REG_NODE_COUNT = 3'd0,
        REG_EDGE_COUNT = 3'd1,
        REG_DAMPING    = 3'd2,
        REG_ITER_LIMIT = 3'd3,
        REG_TOLERANCE  = 3'd4
    } t_reg_idx;

    typedef enum logic [29:0] {
        ST_IDLE   = 30'b1 << 0,
        ST_CLR    = 30'b1 << 1,
        ST_SUM_RE = 30'b1 << 2,
        ST_SUM_RO = 30'b1 << 3,
        ST_SUM_WR = 30'b1 << 4,
        ST_NRM_RE = 30'b1 << 5,
        ST_NRM_RO = 30'b1 << 6,
        ST_NRM_DS = 30'b1 << 7,
        ST_NRM_DW = 30'b1 << 8,
        ST_MM_RD  = 30'b1 << 9,
        ST_MM_UP  = 30'b1 << 10,
        ST_PQ_RD  = 30'b1 << 11,
        ST_PQ_DS  = 30'b1 << 12,
        ST_PQ_DW  = 30'b1 << 13,
        ST_IN_RD  = 30'b1 << 14,
        ST_IN_WR  = 30'b1 << 15,
        ST_IT_CHK = 30'b1 << 16,
        ST_NX_RD  = 30'b1 << 17,
        ST_NX_MUL = 30'b1 << 18,
        ST_NX_WR  = 30'b1 << 19,
        ST_ED_RE  = 30'b1 << 20,
        ST_ED_RS  = 30'b1 << 21,
        ST_ED_T   = 30'b1 << 22,
        ST_ED_C   = 30'b1 << 23,
        ST_ED_W   = 30'b1 << 24,
        ST_DF_RD  = 30'b1 << 25,
        ST_DF_AC  = 30'b1 << 26,
        ST_IT_END = 30'b1 << 27,
        ST_DONE   = 30'b1 << 28,
        ST_RD_OUT = 30'b1 << 29
    } t_state;

    typedef struct packed {
        t_state             state;
        logic [EDGE_AW:0]   k;
        logic [NODE_AW:0]   i;
    } t_ctl_cmd;

    typedef struct packed {
        logic edge_ok;
        logic div_need;
        logic div_done;
        logic diff_lt_tol;
        logic diff_zero;
    } t_ctl_sts;
endpackage
`default_nettype wire

FILE: src/ppr_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module ppr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: src/ppr_div.sv
// restoring divider: (a * 2^32) / d, one quotient bit per cycle
`default_nettype none
module ppr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ppr_pkg::VAL_W-1:0]   i_a,
    input  logic [ppr_pkg::OWS_W-1:0]   i_d,
    output logic                        o_done,
    output logic [ppr_pkg::NORM_W-1:0]  o_q
);
    import ppr_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DIV_CW-1:0]   r_cnt, n_cnt;
    logic [OWS_W:0]      r_rem, n_rem;
    logic [NORM_W-1:0]   r_q, n_q;
    logic [OWS_W-1:0]    r_d, n_d;
    logic                r_a0, n_a0;
    logic [OWS_W:0]      rem_sh;
    logic                ge;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_d    = r_d;
        n_a0   = r_a0;
        // only the lowest bit of a lands inside the quotient window
        rem_sh = {r_rem[OWS_W-1:0], (r_cnt == DIV_CW'(NORM_W - 1)) ? r_a0 : 1'b0};
        ge     = rem_sh >= {1'b0, r_d};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CW'(NORM_W - 1);
            n_rem  = (OWS_W + 1)'(i_a >> 1);
            n_d    = i_d;
            n_a0   = i_a[0];
        end else if (r_busy) begin
            n_rem = ge ? (rem_sh - {1'b0, r_d}) : rem_sh;
            n_q   = {r_q[NORM_W-2:0], ge};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_d   <= n_d;
        r_a0  <= n_a0;
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

FILE: src/ppr_dp.sv
// datapath: edge, preference and score memories, divider, multipliers
`default_nettype none
module ppr_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppr_pkg::t_ctl_cmd             i_cmd,
    output ppr_pkg::t_ctl_sts             o_sts,
    input  logic [ppr_pkg::NODE_AW:0]     i_n,
    input  logic [ppr_pkg::DAMP_W-1:0]    i_damping,
    input  logic [ppr_pkg::SCORE_W-1:0]   i_tolerance,
    input  logic                          i_load_edge,
    input  logic                          i_load_pref,
    input  logic                          i_read_score,
    input  logic [ppr_pkg::EDGE_AW-1:0]   i_edge_slot,
    input  logic [ppr_pkg::NODE_AW-1:0]   i_src_node,
    input  logic [ppr_pkg::NODE_AW-1:0]   i_dst_node,
    input  logic [ppr_pkg::VAL_W-1:0]     i_value,
    output logic [ppr_pkg::SCORE_W-1:0]   o_score,
    output logic                          o_saturated
);
    import ppr_pkg::*;

    t_state st;
    assign st = i_cmd.state;

    logic [NODE_AW-1:0] idx;
    logic [EDGE_AW-1:0] kdx;
    assign idx = i_cmd.i[NODE_AW-1:0];
    assign kdx = i_cmd.k[EDGE_AW-1:0];

    // memory ports
    logic [EDGE_W-1:0]  edge_rd;
    logic               edge_re;
    logic [VAL_W-1:0]   pref_rd;
    logic               pref_re;
    logic               ows_we, ows_re;
    logic [NODE_AW-1:0] ows_waddr;
    logic [OWS_W-1:0]   ows_wdata, ows_rd;
    logic               norm_we, norm_re;
    logic [NORM_W-1:0]  norm_wdata, norm_rd;
    logic               pq_we, pq_re;
    logic [NORM_W-1:0]  pq_rd;
    logic               sc_we, sc_re;
    logic [NODE_AW-1:0] sc_raddr;
    logic [SCORE_W-1:0] sc_wdata, sc_rd;
    logic               nx_we, nx_re;
    logic [NODE_AW-1:0] nx_waddr, nx_raddr;
    logic [SCORE_W-1:0] nx_wdata, nx_rd;

    logic [NODE_AW-1:0] e_src, e_dst;
    logic [VAL_W-1:0]   e_wt;
    assign e_src = edge_rd[NODE_AW-1:0];
    assign e_dst = edge_rd[2*NODE_AW-1:NODE_AW];
    assign e_wt  = edge_rd[EDGE_W-1:2*NODE_AW];

    // run registers
    logic [LO_W-1:0]     r_lo;
    logic [VAL_W-1:0]    r_hi;
    logic [DIFF_W-1:0]   r_diff;
    logic                r_sat, r_ran;
    logic [SCORE_W-1:0]  r_t;
    logic [SCORE_W+16:0] r_p1;
    logic [SCORE_W+15:0] r_p2;
    logic [33:0]         r_nx;

    logic              edge_ok, hl_eq, div_start, div_done;
    logic [VAL_W-1:0]  div_a;
    logic [OWS_W-1:0]  div_d;
    logic [NORM_W-1:0] div_q;

    assign edge_ok = ({1'b0, e_src} < i_n) && ({1'b0, e_dst} < i_n);
    assign hl_eq   = r_hi == VAL_W'(r_lo);

    assign div_start = ((st == ST_NRM_DS) && edge_ok && (ows_rd != '0)) || (st == ST_PQ_DS);
    assign div_a = (st == ST_NRM_DS) ? e_wt : (hl_eq ? VAL_W'(1) : (pref_rd - VAL_W'(r_lo)));
    assign div_d = (st == ST_NRM_DS) ? ows_rd
                 : (hl_eq ? OWS_W'(i_n) : OWS_W'(r_hi - VAL_W'(r_lo)));

    ppr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (div_a),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // arithmetic
    logic [63:0]         t_full;
    logic [SCORE_W+16:0] p1;
    logic [SCORE_W+15:0] p2;
    logic [SCORE_W+17:0] c_sum;
    logic [SCORE_W+1:0]  c;
    logic [SCORE_W+2:0]  v;
    logic [SCORE_W-1:0]  v_sat;
    logic [LO_W-1:0]     keep;
    logic [49:0]         nx_prod;
    logic [SCORE_W-1:0]  abs_d;

    assign t_full  = 64'(sc_rd) * 64'(i_damping);
    assign p1      = (SCORE_W + 17)'(r_t) * (SCORE_W + 17)'(norm_rd[NORM_W-1:16]);
    assign p2      = (SCORE_W + 16)'(r_t) * (SCORE_W + 16)'(norm_rd[15:0]);
    assign c_sum   = (SCORE_W + 18)'(r_p1) + (SCORE_W + 18)'(r_p2[SCORE_W+15:16]);
    assign c       = c_sum[SCORE_W+17:16];
    assign v       = (SCORE_W + 3)'(nx_rd) + (SCORE_W + 3)'(c);
    assign v_sat   = (v[SCORE_W+2:SCORE_W] != '0) ? SCORE_MAX : v[SCORE_W-1:0];
    assign keep    = LO_W'(17'h10000) - LO_W'(i_damping);
    assign nx_prod = 50'(keep) * 50'(pq_rd);
    assign abs_d   = (nx_rd > sc_rd) ? (nx_rd - sc_rd) : (sc_rd - nx_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
            r_ran <= 1'b0;
        end else begin
            if (st == ST_CLR) begin
                r_sat <= 1'b0;
            end else if ((st == ST_ED_W) && (v[SCORE_W+2:SCORE_W] != '0)) begin
                r_sat <= 1'b1;
            end
            if (st == ST_IN_WR) begin
                r_ran <= 1'b1;
            end
        end
        if (st == ST_CLR) begin
            r_lo <= LO_W'(17'h10000);
            r_hi <= '0;
        end else if (st == ST_MM_UP) begin
            if (pref_rd > r_hi) begin
                r_hi <= pref_rd;
            end
            if (pref_rd < VAL_W'(r_lo)) begin
                r_lo <= pref_rd[LO_W-1:0];
            end
        end
        if (st == ST_IT_CHK) begin
            r_diff <= '0;
        end else if (st == ST_DF_AC) begin
            r_diff <= r_diff + DIFF_W'(abs_d);
        end
        r_t  <= t_full[63:16];
        r_p1 <= p1;
        r_p2 <= p2;
        r_nx <= nx_prod[49:16];
    end

    // port steering
    assign edge_re = (st == ST_SUM_RE) || (st == ST_NRM_RE) || (st == ST_ED_RE);
    assign pref_re = (st == ST_MM_RD) || (st == ST_PQ_RD);
    assign ows_re  = (st == ST_SUM_RO) || (st == ST_NRM_RO);
    assign ows_we  = (st == ST_CLR) || (st == ST_SUM_WR);
    assign ows_waddr = (st == ST_CLR) ? idx : e_src;
    assign ows_wdata = (st == ST_CLR) ? '0 : (ows_rd + OWS_W'(e_wt));
    assign norm_re = st == ST_ED_RE;
    assign norm_we = ((st == ST_NRM_DS) && !div_start) || ((st == ST_NRM_DW) && div_done);
    assign norm_wdata = (st == ST_NRM_DS) ? '0 : div_q;
    assign pq_re = (st == ST_IN_RD) || (st == ST_NX_RD);
    assign pq_we = (st == ST_PQ_DW) && div_done;
    assign sc_re = i_read_score || ((st == ST_ED_RS) && edge_ok) || (st == ST_DF_RD);
    assign sc_we = (st == ST_IN_WR) || (st == ST_DF_AC);
    assign sc_wdata = (st == ST_DF_AC) ? nx_rd
                    : ((i_cmd.i < i_n) ? SCORE_W'(pq_rd) : '0);
    assign nx_re = (st == ST_ED_C) || (st == ST_DF_RD);
    assign nx_raddr = (st == ST_ED_C) ? e_dst : idx;
    assign nx_we = (st == ST_NX_WR) || (st == ST_ED_W);
    assign nx_waddr = (st == ST_ED_W) ? e_dst : idx;
    assign nx_wdata = (st == ST_ED_W) ? v_sat : SCORE_W'(r_nx);

    always_comb begin
        unique case (st)
            ST_ED_RS: sc_raddr = e_src;
            ST_DF_RD: sc_raddr = idx;
            default:  sc_raddr = i_src_node;
        endcase
    end

    ppr_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk(i_clk), .i_we(i_load_edge), .i_waddr(i_edge_slot),
        .i_wdata({i_value, i_dst_node, i_src_node}),
        .i_re(edge_re), .i_raddr(kdx), .o_rdata(edge_rd)
    );

    ppr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_pref_ram (
        .i_clk(i_clk), .i_we(i_load_pref), .i_waddr(i_src_node), .i_wdata(i_value),
        .i_re(pref_re), .i_raddr(idx), .o_rdata(pref_rd)
    );

    ppr_ram #(.WIDTH(OWS_W), .DEPTH(MAX_NODES)) u_ows_ram (
        .i_clk(i_clk), .i_we(ows_we), .i_waddr(ows_waddr), .i_wdata(ows_wdata),
        .i_re(ows_re), .i_raddr(e_src), .o_rdata(ows_rd)
    );

    ppr_ram #(.WIDTH(NORM_W), .DEPTH(MAX_EDGES)) u_norm_ram (
        .i_clk(i_clk), .i_we(norm_we), .i_waddr(kdx), .i_wdata(norm_wdata),
        .i_re(norm_re), .i_raddr(kdx), .o_rdata(norm_rd)
    );

    ppr_ram #(.WIDTH(NORM_W), .DEPTH(MAX_NODES)) u_prefq_ram (
        .i_clk(i_clk), .i_we(pq_we), .i_waddr(idx), .i_wdata(div_q),
        .i_re(pq_re), .i_raddr(idx), .o_rdata(pq_rd)
    );

    ppr_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_score_ram (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(idx), .i_wdata(sc_wdata),
        .i_re(sc_re), .i_raddr(sc_raddr), .o_rdata(sc_rd)
    );

    ppr_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_NODES)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_re(nx_re), .i_raddr(nx_raddr), .o_rdata(nx_rd)
    );

    always_comb begin
        o_sts.edge_ok     = edge_ok;
        o_sts.div_need    = div_start;
        o_sts.div_done    = div_done;
        o_sts.diff_lt_tol = r_diff < DIFF_W'(i_tolerance);
        o_sts.diff_zero   = r_diff == '0;
    end

    // scores read before any run are zero
    assign o_score     = r_ran ? sc_rd : '0;
    assign o_saturated = r_sat;
endmodule
`default_nettype wire

FILE: src/ppr_ctrl.sv
// controller: run sequencing over edges, nodes and iterations
`default_nettype none
module ppr_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start_run,
    input  logic                         i_start_read,
    input  logic [ppr_pkg::NODE_AW:0]    i_n,
    input  logic [ppr_pkg::EDGE_AW:0]    i_ne,
    input  logic [ppr_pkg::CNT_W-1:0]    i_limit,
    input  ppr_pkg::t_ctl_sts            i_sts,
    input  logic                         i_out_free,
    output ppr_pkg::t_ctl_cmd            o_cmd,
    output logic [ppr_pkg::CNT_W-1:0]    o_iters,
    output logic                         o_converged,
    output logic                         o_out_load
);
    import ppr_pkg::*;

    t_state           r_state, n_state;
    logic [EDGE_AW:0] r_k, n_k;
    logic [NODE_AW:0] r_i, n_i;
    logic [CNT_W-1:0] r_it, n_it;
    logic             r_conv, n_conv;
    logic             i_last, k_last, ne_zero, all_last;

    assign i_last   = r_i == (i_n - 1'b1);
    assign all_last = r_i == (NODE_AW + 1)'(MAX_NODES - 1);
    assign k_last   = r_k == (i_ne - 1'b1);
    assign ne_zero  = i_ne == '0;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_it    = r_it;
        n_conv  = r_conv;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start_run) begin
                    n_i = '0; n_k = '0; n_it = '0; n_conv = 1'b0;
                    n_state = ST_CLR;
                end else if (i_start_read) begin
                    n_state = ST_RD_OUT;
                end
            end
            ST_CLR: begin
                if (i_last) begin
                    n_i = '0;
                    n_state = ne_zero ? ST_MM_RD : ST_SUM_RE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            ST_SUM_RE: n_state = ST_SUM_RO;
            ST_SUM_RO, ST_SUM_WR: begin
                if ((r_state == ST_SUM_RO) && i_sts.edge_ok) begin
                    n_state = ST_SUM_WR;
                end else if (k_last) begin
                    n_k = '0; n_state = ST_NRM_RE;
                end else begin
                    n_k = r_k + 1'b1; n_state = ST_SUM_RE;
                end
            end
            ST_NRM_RE: n_state = ST_NRM_RO;
            ST_NRM_RO: n_state = ST_NRM_DS;
            ST_NRM_DS, ST_NRM_DW: begin
                if ((r_state == ST_NRM_DS) && i_sts.div_need) begin
                    n_state = ST_NRM_DW;
                end else if ((r_state == ST_NRM_DW) && !i_sts.div_done) begin
                    n_state = ST_NRM_DW;
                end else if (k_last) begin
                    n_k = '0; n_state = ST_MM_RD;
                end else begin
                    n_k = r_k + 1'b1; n_state = ST_NRM_RE;
                end
            end
            ST_MM_RD: n_state = ST_MM_UP;
            ST_MM_UP: begin
                if (i_last) begin
                    n_i = '0; n_state = ST_PQ_RD;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_MM_RD;
                end
            end
            ST_PQ_RD: n_state = ST_PQ_DS;
            ST_PQ_DS: n_state = ST_PQ_DW;
            ST_PQ_DW: begin
                if (i_sts.div_done) begin
                    if (i_last) begin
                        n_i = '0; n_state = ST_IN_RD;
                    end else begin
                        n_i = r_i + 1'b1; n_state = ST_PQ_RD;
                    end
                end
            end
            ST_IN_RD: n_state = ST_IN_WR;
            ST_IN_WR: begin
                // every node is written, nodes past the count get zero
                if (all_last) begin
                    n_i = '0; n_state = ST_IT_CHK;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_IN_RD;
                end
            end
            ST_IT_CHK: begin
                n_i = '0;
                n_state = (r_it < i_limit) ? ST_NX_RD : ST_DONE;
            end
            ST_NX_RD:  n_state = ST_NX_MUL;
            ST_NX_MUL: n_state = ST_NX_WR;
            ST_NX_WR: begin
                if (i_last) begin
                    n_i = '0; n_k = '0;
                    n_state = ne_zero ? ST_DF_RD : ST_ED_RE;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_NX_RD;
                end
            end
            ST_ED_RE: n_state = ST_ED_RS;
            ST_ED_T:  n_state = ST_ED_C;
            ST_ED_C:  n_state = ST_ED_W;
            ST_ED_RS, ST_ED_W: begin
                if ((r_state == ST_ED_RS) && i_sts.edge_ok) begin
                    n_state = ST_ED_T;
                end else if (k_last) begin
                    n_k = '0; n_i = '0; n_state = ST_DF_RD;
                end else begin
                    n_k = r_k + 1'b1; n_state = ST_ED_RE;
                end
            end
            ST_DF_RD: n_state = ST_DF_AC;
            ST_DF_AC: begin
                if (i_last) begin
                    n_state = ST_IT_END;
                end else begin
                    n_i = r_i + 1'b1; n_state = ST_DF_RD;
                end
            end
            ST_IT_END: begin
                n_it = r_it + 1'b1;
                if (i_sts.diff_lt_tol) begin
                    n_conv = 1'b1; n_state = ST_DONE;
                end else if (i_sts.diff_zero) begin
                    // fixed point reached without passing tolerance
                    n_it = i_limit; n_state = ST_DONE;
                end else begin
                    n_state = ST_IT_CHK;
                end
            end
            ST_DONE, ST_RD_OUT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_it    <= '0;
            r_conv  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_it    <= n_it;
            r_conv  <= n_conv;
        end
    end

    always_comb begin
        o_cmd.state = r_state;
        o_cmd.k     = r_k;
        o_cmd.i     = r_i;
    end

    assign o_iters     = r_it;
    assign o_converged = r_conv;
    assign o_out_load  = ((r_state == ST_DONE) || (r_state == ST_RD_OUT)) && i_out_free;
endmodule
`default_nettype wire

FILE: src/personalized_pagerank_engine_top.sv
// Personalized pagerank engine top: config registers, stream ports, output register.
// Edge and preference loads are accepted back to back while the controller is idle.
// A score read is registered out of the score ram and loaded into the result register once that
// register is free; a run is sequenced by the controller over the edges, nodes and iterations,
// using the memories and the bit-serial divider.
// Synchronous active-low reset restores register defaults; scores read as zero until a run.
`default_nettype none
`include "personalized_pagerank_engine_top_macros.svh"
module personalized_pagerank_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // edge_slot, src_node, dst_node, value
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // score, iterations_done, converged, saturated
    output logic [0:0]  m_axis_tuser   // kind
);
    import ppr_pkg::*;

    logic [NODE_AW:0]   r_node_count;
    logic [EDGE_AW:0]   r_edge_count;
    logic [DAMP_W-1:0]  r_damping;
    logic [CNT_W-1:0]   r_iter_limit;
    logic [SCORE_W-1:0] r_tolerance;
    t_reg_idx           reg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= (NODE_AW + 1)'(1);
            r_edge_count <= '0;
            r_damping    <= DAMP_W'(55706);
            r_iter_limit <= CNT_W'(100);
            r_tolerance  <= SCORE_W'(4295);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NODE_COUNT: r_node_count <= pwdata[NODE_AW:0];
                REG_EDGE_COUNT: r_edge_count <= pwdata[EDGE_AW:0];
                REG_DAMPING:    r_damping    <= pwdata[DAMP_W-1:0];
                REG_ITER_LIMIT: r_iter_limit <= pwdata[CNT_W-1:0];
                REG_TOLERANCE:  r_tolerance  <= pwdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NODE_COUNT: prdata = 64'(r_node_count);
            REG_EDGE_COUNT: prdata = 64'(r_edge_count);
            REG_DAMPING:    prdata = 64'(r_damping);
            REG_ITER_LIMIT: prdata = 64'(r_iter_limit);
            REG_TOLERANCE:  prdata = 64'(r_tolerance);
            default:        prdata = '0;
        endcase
    end

    // effective node and edge counts
    logic [NODE_AW:0] eff_n;
    logic [EDGE_AW:0] eff_ne;
    assign eff_n = (r_node_count > (NODE_AW + 1)'(MAX_NODES)) ? (NODE_AW + 1)'(MAX_NODES)
                 : ((r_node_count == '0) ? (NODE_AW + 1)'(1) : r_node_count);
    assign eff_ne = (r_edge_count > (EDGE_AW + 1)'(MAX_EDGES)) ? (EDGE_AW + 1)'(MAX_EDGES)
                  : r_edge_count;

    t_ctl_cmd  ctl_cmd;
    t_ctl_sts  ctl_sts;
    t_cmd_code in_cmd;
    logic      in_acc, out_free, out_load, conv, sat;
    logic [CNT_W-1:0]   iters;
    logic [SCORE_W-1:0] dp_score;
    logic               r_out_valid;
    logic [71:0]        r_out_data;
    logic               r_out_kind;

    assign in_cmd        = t_cmd_code'(s_axis_tuser);
    assign s_axis_tready = ctl_cmd.state == ST_IDLE;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    ppr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_run  (in_acc && (in_cmd == CMD_RUN)),
        .i_start_read (in_acc && (in_cmd == CMD_READ)),
        .i_n          (eff_n),
        .i_ne         (eff_ne),
        .i_limit      (r_iter_limit),
        .i_sts        (ctl_sts),
        .i_out_free   (out_free),
        .o_cmd        (ctl_cmd),
        .o_iters      (iters),
        .o_converged  (conv),
        .o_out_load   (out_load)
    );

    ppr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (ctl_cmd),
        .o_sts        (ctl_sts),
        .i_n          (eff_n),
        .i_damping    (r_damping),
        .i_tolerance  (r_tolerance),
        .i_load_edge  (in_acc && (in_cmd == CMD_LOAD_EDGE)),
        .i_load_pref  (in_acc && (in_cmd == CMD_LOAD_PREF)),
        .i_read_score (in_acc && (in_cmd == CMD_READ)),
        .i_edge_slot  (s_axis_tdata[11:0]),
        .i_src_node   (s_axis_tdata[21:12]),
        .i_dst_node   (s_axis_tdata[31:22]),
        .i_value      (s_axis_tdata[63:32]),
        .o_score      (dp_score),
        .o_saturated  (sat)
    );

    // result register decouples the result side from the input side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            if (ctl_cmd.state == ST_RD_OUT) begin
                r_out_kind <= 1'b1;
                r_out_data <= {8'b0, 16'b0, dp_score};
            end else begin
                r_out_kind <= 1'b0;
                r_out_data <= {6'b0, sat, conv, iters, 48'b0};
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    `PPR_ASSERT_NEXT(a_run_holds_off_input,
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_RUN), !s_axis_tready,
        "input accepted right after a run transaction")
    `PPR_ASSERT_NOW(a_load_into_free_slot, out_load, !r_out_valid || m_axis_tready,
        "result register overwritten while holding an untaken transaction")
    `PPR_ASSERT_NOW(a_status_has_no_score, m_axis_tvalid && (m_axis_tuser == 1'b0),
        m_axis_tdata[47:0] == 48'b0, "run status carries a nonzero score")
endmodule
`default_nettype wire

FILE: verif/ppr_rank_checker.sv
// checker for the pagerank engine: watches config and stream channels, predicts and compares
`default_nettype none
module ppr_rank_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // edge_slot, src_node, dst_node, value
    input  wire logic [1:0]  s_axis_tuser,  // cmd
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [71:0] m_axis_tdata,  // score, iterations_done, converged, saturated
    input  wire logic [0:0]  m_axis_tuser,  // kind
    output int               o_fail_count,
    output int               o_pending
);
    import ppr_pkg::*;

    typedef struct packed {
        logic         kind;
        logic [47:0]  score;
        logic [15:0]  iters;
        logic         conv;
        logic         sat;
    } t_rank_result;

    t_rank_result expected_results[$];

    logic [10:0] cfg_nodes = 11'd1;
    logic [12:0] cfg_edges = 13'd0;
    logic [15:0] cfg_damp  = 16'd55706;
    logic [15:0] cfg_ilim  = 16'd100;
    logic [47:0] cfg_tol   = 48'd4295;

    int unsigned      edge_src_mem [MAX_EDGES];
    int unsigned      edge_dst_mem [MAX_EDGES];
    longint unsigned  edge_wt_mem  [MAX_EDGES];
    longint unsigned  edge_norm    [MAX_EDGES];
    bit               edge_live    [MAX_EDGES];
    longint unsigned  pref_raw     [MAX_NODES];
    longint unsigned  pref_norm    [MAX_NODES];
    longint unsigned  out_wsum     [MAX_NODES];
    longint unsigned  cur_score    [MAX_NODES];
    longint unsigned  nxt_score    [MAX_NODES];

    function automatic longint unsigned scale_q32(longint unsigned t, longint unsigned w);
        longint unsigned whi, wlo;
        whi = w >> 16;
        wlo = w & 64'hFFFF;
        return ((t * whi) + ((t * wlo) >> 16)) >> 16;
    endfunction

    task automatic compute_rank_run(output t_rank_result res);
        longint unsigned n, ne, lo, hi, keep, it, s, diff, t, v, a, b;
        bit conv, sat;
        n = cfg_nodes;
        ne = cfg_edges;
        lo = 64'd65536;
        hi = 0;
        it = 0;
        conv = 0;
        sat = 0;
        if (n > MAX_NODES) n = MAX_NODES;
        if (n == 0) n = 1;
        if (ne > MAX_EDGES) ne = MAX_EDGES;
        for (int i = 0; i < MAX_NODES; i++) out_wsum[i] = 0;
        for (int k = 0; k < ne; k++) begin
            edge_live[k] = edge_src_mem[k] < n && edge_dst_mem[k] < n;
            if (edge_live[k]) out_wsum[edge_src_mem[k]] += edge_wt_mem[k];
        end
        for (int k = 0; k < ne; k++) begin
            s = edge_live[k] ? out_wsum[edge_src_mem[k]] : 0;
            edge_norm[k] = (s != 0) ? ((edge_wt_mem[k] << 32) / s) : 0;
        end
        for (int i = 0; i < n; i++) begin
            if (pref_raw[i] > hi) hi = pref_raw[i];
            if (pref_raw[i] < lo) lo = pref_raw[i];
        end
        for (int i = 0; i < n; i++) begin
            if (hi == lo) pref_norm[i] = (64'd1 << 32) / n;
            else          pref_norm[i] = ((pref_raw[i] - lo) << 32) / (hi - lo);
        end
        for (int i = 0; i < MAX_NODES; i++) begin
            cur_score[i] = (i < n) ? pref_norm[i] : 0;
            nxt_score[i] = 0;
        end
        keep = 64'd65536 - cfg_damp;
        while (it < cfg_ilim) begin
            diff = 0;
            for (int i = 0; i < n; i++) nxt_score[i] = (keep * pref_norm[i]) >> 16;
            for (int k = 0; k < ne; k++) begin
                if (edge_live[k]) begin
                    t = (cur_score[edge_src_mem[k]] * cfg_damp) >> 16;
                    v = nxt_score[edge_dst_mem[k]] + scale_q32(t, edge_norm[k]);
                    if (v > 64'hFFFF_FFFF_FFFF) begin
                        v = 64'hFFFF_FFFF_FFFF;
                        sat = 1;
                    end
                    nxt_score[edge_dst_mem[k]] = v;
                end
            end
            for (int i = 0; i < n; i++) begin
                a = nxt_score[i];
                b = cur_score[i];
                diff += (a > b) ? a - b : b - a;
                cur_score[i] = a;
            end
            it++;
            if (diff < cfg_tol) begin
                conv = 1;
                break;
            end
            // exact fixed point ends the run as if the limit were hit
            if (diff == 0) begin
                it = cfg_ilim;
                break;
            end
        end
        res.kind  = 1'b0;
        res.score = '0;
        res.iters = it[15:0];
        res.conv  = conv;
        res.sat   = sat;
    endtask

    always @(posedge i_clk) begin
        t_rank_result res, got;
        logic [11:0] slot;
        logic [9:0]  src, dst;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[5:3]))
                    REG_NODE_COUNT: cfg_nodes = pwdata[10:0];
                    REG_EDGE_COUNT: cfg_edges = pwdata[12:0];
                    REG_DAMPING:    cfg_damp  = pwdata[15:0];
                    REG_ITER_LIMIT: cfg_ilim  = pwdata[15:0];
                    REG_TOLERANCE:  cfg_tol   = pwdata[47:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                slot = s_axis_tdata[11:0];
                src  = s_axis_tdata[21:12];
                dst  = s_axis_tdata[31:22];
                case (t_cmd_code'(s_axis_tuser))
                    CMD_LOAD_EDGE: begin
                        edge_src_mem[slot] = src;
                        edge_dst_mem[slot] = dst;
                        edge_wt_mem[slot]  = s_axis_tdata[63:32];
                    end
                    CMD_LOAD_PREF: pref_raw[src] = s_axis_tdata[63:32];
                    CMD_RUN: begin
                        compute_rank_run(res);
                        expected_results.push_back(res);
                    end
                    default: begin
                        res = '0;
                        res.kind  = 1'b1;
                        res.score = cur_score[src][47:0];
                        expected_results.push_back(res);
                    end
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind  = m_axis_tuser[0];
                got.score = m_axis_tdata[47:0];
                got.iters = m_axis_tdata[63:48];
                got.conv  = m_axis_tdata[64];
                got.sat   = m_axis_tdata[65];
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_fail_count++;
                end else begin
                    res = expected_results.pop_front();
                    if (got.kind !== res.kind) begin
                        $error("kind: expected %0d actual %0d", res.kind, got.kind);
                        o_fail_count++;
                    end
                    if (got.score !== res.score) begin
                        $error("score: expected %0h actual %0h", res.score, got.score);
                        o_fail_count++;
                    end
                    if (got.iters !== res.iters) begin
                        $error("iterations_done: expected %0d actual %0d", res.iters, got.iters);
                        o_fail_count++;
                    end
                    if (got.conv !== res.conv) begin
                        $error("converged: expected %0d actual %0d", res.conv, got.conv);
                        o_fail_count++;
                    end
                    if (got.sat !== res.sat) begin
                        $error("saturated: expected %0d actual %0d", res.sat, got.sat);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule
`default_nettype wire

FILE: verif/tb_personalized_pagerank_engine_top.sv
// testbench top for the pagerank engine: stimulus, config writes and verdict
`default_nettype none
module tb_personalized_pagerank_engine_top;
    import ppr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_data = '0;
    logic [1:0]  s_user = '0;
    logic        m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    int          fail_count, pending;

    int  items_sent = 0;
    int  send_idle_pct = 16;
    int  recv_idle_pct = 48;
    bit  pref_loaded [MAX_NODES];
    bit  edge_loaded [MAX_EDGES];
    int  eff_nodes = 1;
    int  eff_edges = 0;

    personalized_pagerank_engine_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    ppr_rank_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(t_cmd_code cmd, logic [11:0] slot, logic [9:0] src,
                             logic [9:0] dst, logic [31:0] val);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? 1 : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {val, dst, src, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_LOAD_EDGE) edge_loaded[slot] = 1'b1;
        if (cmd == CMD_LOAD_PREF) pref_loaded[src] = 1'b1;
        items_sent++;
    endtask

    task automatic reg_write(t_reg_idx idx, logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // let every result drain and the block settle before touching registers
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic configure(int n, int e, int damp, int ilim, logic [47:0] tol);
        wait_quiet();
        reg_write(REG_NODE_COUNT, n);
        reg_write(REG_EDGE_COUNT, e);
        reg_write(REG_DAMPING, damp);
        reg_write(REG_ITER_LIMIT, ilim);
        reg_write(REG_TOLERANCE, tol);
        eff_nodes = (n == 0) ? 1 : (n > MAX_NODES ? MAX_NODES : n);
        eff_edges = (e > MAX_EDGES) ? MAX_EDGES : e;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 32'h1FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] pick_endpoint();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, eff_nodes - 1);
    endfunction

    // fill every entry a run will read, then a random mix of traffic
    task automatic traffic_phase(int count);
        bit refresh;
        logic [31:0] same;
        refresh = eff_nodes <= 64;
        same = pick_value();
        for (int i = 0; i < eff_nodes; i++)
            if (!pref_loaded[i] || (refresh && $urandom_range(0, 1)))
                send_item(CMD_LOAD_PREF, $urandom, i, $urandom,
                          ($urandom_range(0, 7) == 0) ? same : pick_value());
        for (int k = 0; k < eff_edges; k++)
            if (!edge_loaded[k] || (refresh && $urandom_range(0, 1)))
                send_item(CMD_LOAD_EDGE, k, pick_endpoint(), pick_endpoint(), pick_value());
        for (int j = 0; j < count; j++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(CMD_LOAD_EDGE,
                          (eff_edges > 0 && r < 35) ? $urandom_range(0, eff_edges - 1)
                                                    : $urandom,
                          pick_endpoint(), pick_endpoint(), pick_value());
            else if (r < 70)
                send_item(CMD_LOAD_PREF, $urandom,
                          (r < 66) ? $urandom_range(0, eff_nodes - 1) : $urandom,
                          $urandom, pick_value());
            else if (r < 75)
                send_item(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
            else
                send_item(CMD_READ, $urandom, ($urandom_range(0, 3) == 0) ? $urandom
                          : $urandom_range(0, eff_nodes - 1), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [47:0] tol;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scores read as zero before any run
        send_item(CMD_READ, 0, 0, 0, 0);
        send_item(CMD_READ, 12'hFFF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
        send_item(CMD_LOAD_PREF, 0, 0, 0, 32'h0);
        send_item(CMD_RUN, 0, 0, 0, 0);

        configure(2, 3, 55706, 100, 48'd4295);
        send_item(CMD_LOAD_PREF, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(CMD_LOAD_PREF, 0, 1, 0, 32'h0);
        send_item(CMD_LOAD_EDGE, 0, 0, 1, 32'hFFFF_FFFF);
        // zero out-weight source
        send_item(CMD_LOAD_EDGE, 1, 1, 0, 32'h0);
        // endpoint beyond the node count is ignored
        send_item(CMD_LOAD_EDGE, 2, 0, 10'h3FF, 32'h1234_5678);
        send_item(CMD_LOAD_EDGE, 12'hFFF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 1, 0, 0);
        send_item(CMD_READ, 0, 10'h3FF, 0, 0);

        // iteration limit zero leaves the preferences
        configure(2, 3, 65535, 0, 48'd0);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 0, 0, 0);
        // node count zero taken as one, no damping
        configure(0, 3, 0, 5, 48'd0);
        send_item(CMD_RUN, 0, 0, 0, 0);
        // equal preferences give one over n
        configure(2, 2, 65535, 65535, 48'hFFFF_FFFF_FFFF);
        send_item(CMD_LOAD_PREF, 0, 0, 0, 32'd5);
        send_item(CMD_LOAD_PREF, 0, 1, 0, 32'd5);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 1, 0, 0);
        // largest edge count written, no run while slots are unwritten
        configure(2, 4096, 30000, 3, 48'd100);
        send_item(CMD_READ, 0, 0, 0, 0);

        // full node range, then node count above range capped
        configure(1024, 4, 55706, 2, 48'd4295);
        traffic_phase(10);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 10'h3FF, 0, 0);
        configure(2047, 4, 20000, 1, 48'd0);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, 0, 10'h200, 0, 0);

        while (items_sent < 1800) begin
            case ($urandom_range(0, 3))
                0: tol = 48'd0;
                1: tol = $urandom_range(0, 10000);
                2: tol = 48'd4295;
                default: tol = {$urandom, $urandom} & 48'h0FFF_FFFF_FFFF;
            endcase
            if (items_sent > 1550) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent > 1300) begin
                send_idle_pct = 48;
                recv_idle_pct = 16;
            end
            configure($urandom_range(1, 8), $urandom_range(0, 16),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(40000, 62000),
                      $urandom_range(0, 20), tol);
            traffic_phase($urandom_range(40, 90));
        end

        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
